// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, quiet while reset is held.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mcewc_pkg.sv =====
package mcewc_pkg;

  localparam int SENSOR_COUNT_DEF = 3;
  localparam int STAMP_BITS_DEF   = 16;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  echo_levels;
    logic [15:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [15:0] width_sensor0;
    logic [15:0] width_sensor1;
    logic [15:0] width_sensor2;
    logic [1:0]  active_sensor;
    logic        trigger_pulse;
  } out_item_t;

endpackage

// ===== rtl/core/multi_channel_echo_width_capture_unit.sv =====
// Round-robin echo width capture for SENSOR_COUNT ultrasonic sensors. Each
// request is either a pin sample (opcode 0) or a measurement tick (opcode 1);
// every request yields exactly one registered result, and a new request can
// be taken every cycle while the result register is not stalled. Edge
// detect and a STAMP_BITS-wide subtract lie between the state registers and
// the result register. A sample updates only the active sensor's rise or fall
// stamp; a tick stores fall minus rise as that sensor's width, clears its
// remembered level, advances to the next sensor and raises trigger_pulse.
// in_ready stays high while the result register is empty or being drained.
module multi_channel_echo_width_capture_unit #(
  parameter int SENSOR_COUNT = mcewc_pkg::SENSOR_COUNT_DEF,
  parameter int STAMP_BITS   = mcewc_pkg::STAMP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mcewc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mcewc_pkg::out_item_t out_data
);
  import mcewc_pkg::*;

  localparam int IDX_W = $clog2(SENSOR_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

  logic [IDX_W-1:0]      active_r, active_nxt;
  logic                  prev_level_r [SENSOR_COUNT];
  logic                  prev_level_nxt [SENSOR_COUNT];
  logic [STAMP_BITS-1:0] rise_r [SENSOR_COUNT];
  logic [STAMP_BITS-1:0] rise_nxt [SENSOR_COUNT];
  logic [STAMP_BITS-1:0] fall_r [SENSOR_COUNT];
  logic [STAMP_BITS-1:0] fall_nxt [SENSOR_COUNT];
  logic [STAMP_BITS-1:0] width_r [SENSOR_COUNT];
  logic [STAMP_BITS-1:0] width_nxt [SENSOR_COUNT];

  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                    accept;
  logic [SENSOR_COUNT-1:0] level_vec;
  logic                    level;
  logic [STAMP_BITS-1:0]   stamp;
  logic [15:0]             width_sel [3];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sensors past the third have no echo pin and read low.
  assign level_vec = SENSOR_COUNT'(in_data.echo_levels);
  assign level     = level_vec[active_r];
  assign stamp     = STAMP_BITS'(in_data.timestamp);

  always_comb begin
    active_nxt     = active_r;
    prev_level_nxt = prev_level_r;
    rise_nxt       = rise_r;
    fall_nxt       = fall_r;
    width_nxt      = width_r;
    if (accept) begin
      if (in_data.opcode == OP_SAMPLE) begin
        if (level && !prev_level_r[active_r]) begin
          rise_nxt[active_r] = stamp;
        end
        if (!level && prev_level_r[active_r]) begin
          fall_nxt[active_r] = stamp;
        end
        prev_level_nxt[active_r] = level;
      end else begin
        // Stamps are kept; a tick without edges reuses the old pair.
        width_nxt[active_r]      = fall_r[active_r] - rise_r[active_r];
        prev_level_nxt[active_r] = 1'b0;
        active_nxt = (active_r == LAST_IDX) ? '0 : active_r + 1'b1;
      end
    end
  end

  genvar j;
  generate
    for (j = 0; j < 3; j++) begin : g_wsel
      if (j < SENSOR_COUNT) begin : g_on
        assign width_sel[j] = 16'(width_nxt[j]);
      end else begin : g_off
        assign width_sel[j] = '0;
      end
    end
  endgenerate

  always_comb begin
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_data_nxt.width_sensor0 = width_sel[0];
      out_data_nxt.width_sensor1 = width_sel[1];
      out_data_nxt.width_sensor2 = width_sel[2];
      out_data_nxt.active_sensor = 2'(active_nxt);
      out_data_nxt.trigger_pulse = (in_data.opcode == OP_TICK);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        prev_level_r[i] <= 1'b0;
        rise_r[i]       <= '0;
        fall_r[i]       <= '0;
        width_r[i]      <= '0;
      end
    end else begin
      active_r     <= active_nxt;
      out_valid_r  <= out_valid_nxt;
      prev_level_r <= prev_level_nxt;
      rise_r       <= rise_nxt;
      fall_r       <= fall_nxt;
      width_r      <= width_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/core/mcewc_checker.sv =====
`include "assert_macros.svh"

module mcewc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input mcewc_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input mcewc_pkg::out_item_t out_data
);
  import mcewc_pkg::*;

  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")
  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_RST(a_sample_result, clk, rst_n, in_valid && in_ready && in_data.opcode == OP_SAMPLE |=> out_valid && !out_data.trigger_pulse, "sample result missing or triggered")
  `ASSERT_RST(a_tick_result, clk, rst_n, in_valid && in_ready && in_data.opcode == OP_TICK |=> out_valid && out_data.trigger_pulse, "tick result missing trigger")

endmodule

bind multi_channel_echo_width_capture_unit mcewc_checker u_mcewc_checker (.*);

// ===== test/multi_channel_echo_width_capture_unit_tb.sv =====
module multi_channel_echo_width_capture_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcewc_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // Tracks the round-robin capture state and the results it must produce.
  class echo_width_scoreboard;
    logic [1:0]  listen_idx;
    logic        last_level [3];
    logic [15:0] rise_ts [3];
    logic [15:0] fall_ts [3];
    logic [15:0] echo_width [3];
    out_item_t   expected_q [$];
    int          field_errors;
    int          stray_results;
    int          checked;
    int          reported;

    function new();
      listen_idx = 2'd0;
      for (int s = 0; s < 3; s++) begin
        last_level[s] = 1'b0;
        rise_ts[s]    = '0;
        fall_ts[s]    = '0;
        echo_width[s] = '0;
      end
      field_errors  = 0;
      stray_results = 0;
      checked       = 0;
      reported      = 0;
    endfunction

    function void note_request(in_item_t req);
      out_item_t exp_item;
      logic      lvl;
      if (req.opcode == OP_SAMPLE) begin
        lvl = req.echo_levels[listen_idx];
        if (lvl && !last_level[listen_idx]) rise_ts[listen_idx] = req.timestamp;
        if (!lvl && last_level[listen_idx]) fall_ts[listen_idx] = req.timestamp;
        last_level[listen_idx] = lvl;
      end else begin
        echo_width[listen_idx] = fall_ts[listen_idx] - rise_ts[listen_idx];
        last_level[listen_idx] = 1'b0;
        listen_idx = (listen_idx == 2'd2) ? 2'd0 : listen_idx + 2'd1;
      end
      exp_item.width_sensor0 = echo_width[0];
      exp_item.width_sensor1 = echo_width[1];
      exp_item.width_sensor2 = echo_width[2];
      exp_item.active_sensor = listen_idx;
      exp_item.trigger_pulse = (req.opcode == OP_TICK);
      expected_q.push_back(exp_item);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        field_errors++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: result %0d %s expected %h got %h", checked, field, want, got);
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (expected_q.size() == 0) begin
        stray_results++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: result %0d arrived with nothing expected: %h", checked, got);
        end
        return;
      end
      want = expected_q.pop_front();
      compare_field("width_sensor0", want.width_sensor0, got.width_sensor0);
      compare_field("width_sensor1", want.width_sensor1, got.width_sensor1);
      compare_field("width_sensor2", want.width_sensor2, got.width_sensor2);
      compare_field("active_sensor", 16'(want.active_sensor), 16'(got.active_sensor));
      compare_field("trigger_pulse", 16'(want.trigger_pulse), 16'(got.trigger_pulse));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  echo_width_scoreboard sb;
  bit          in_idle = 1'b0;
  bit          out_idle = 1'b0;
  logic [1:0]  stim_sensor = 2'd0;
  logic [15:0] stamp_clock = '0;
  int          requests_sent = 0;
  int          ticks_sent = 0;
  int          stall_cycles = 0;

  multi_channel_echo_width_capture_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_request(input in_item_t req);
    int gap;
    gap = in_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    requests_sent++;
    if (req.opcode == OP_TICK) begin
      ticks_sent++;
      stim_sensor = (stim_sensor == 2'd2) ? 2'd0 : stim_sensor + 2'd1;
    end
  endtask

  // Drive the listened-to sensor's bit; the other bits are noise.
  task automatic send_sample(input logic level, input logic [15:0] stamp);
    logic [2:0] lv;
    lv = 3'($urandom_range(0, 7));
    lv[stim_sensor] = level;
    send_request({OP_SAMPLE, lv, stamp});
  endtask

  task automatic send_tick();
    send_request({OP_TICK, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535))});
  endtask

  task automatic advance_stamp(input int unsigned step);
    stamp_clock = stamp_clock + 16'(step);
  endtask

  // Hold off the sender until every result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input bit in_mode, input bit out_mode);
    int       first;
    in_item_t noise;
    in_idle  = in_mode;
    out_idle = out_mode;
    first    = requests_sent;
    while (requests_sent - first < count) begin
      if ($urandom_range(0, 4) != 0) begin
        // one echo rise on the listened-to sensor, usually followed by its fall, then the tick
        repeat ($urandom_range(0, 2)) begin
          advance_stamp($urandom_range(1, 300));
          send_sample(1'b0, stamp_clock);
        end
        advance_stamp($urandom_range(1, 300));
        send_sample(1'b1, stamp_clock);
        repeat ($urandom_range(0, 3)) begin
          advance_stamp($urandom_range(1, 300));
          send_sample(1'b1, stamp_clock);
        end
        if ($urandom_range(0, 7) != 0) begin
          if ($urandom_range(0, 9) == 0) advance_stamp($urandom_range(0, 65535));
          else advance_stamp($urandom_range(1, 2000));
          send_sample(1'b0, stamp_clock);
        end
        repeat ($urandom_range(0, 2)) begin
          advance_stamp($urandom_range(1, 300));
          send_sample(1'b0, stamp_clock);
        end
        send_tick();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          noise.opcode      = 1'($urandom_range(0, 1));
          noise.echo_levels = 3'($urandom_range(0, 7));
          noise.timestamp   = 16'($urandom_range(0, 65535));
          send_request(noise);
        end
      end
    end
  endtask

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = out_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  initial begin
    in_item_t directed [21];
    int       failures;
    sb = new();
    directed = '{
      {OP_SAMPLE, 3'b000, 16'h0000},  // no edge
      {OP_SAMPLE, 3'b001, 16'h0005},  // sensor 0 rise
      {OP_SAMPLE, 3'b111, 16'h0100},  // still high
      {OP_SAMPLE, 3'b110, 16'h0003},  // fall before rise: width wraps
      {OP_TICK,   3'b111, 16'hFFFF},  // tick ignores its fields
      {OP_SAMPLE, 3'b101, 16'h1234},  // sensor 1 low, others high
      {OP_SAMPLE, 3'b010, 16'h1234},
      {OP_SAMPLE, 3'b000, 16'hFFFF},
      {OP_TICK,   3'b000, 16'h0000},
      {OP_TICK,   3'b100, 16'h8000},  // sensor 2 with no edges at all
      {OP_SAMPLE, 3'b001, 16'h7FFF},  // rise, then tick while high
      {OP_TICK,   3'b001, 16'h0001},
      {OP_TICK,   3'b010, 16'h0002},  // sensor 1 reuses held stamps
      {OP_SAMPLE, 3'b100, 16'h0000},
      {OP_SAMPLE, 3'b011, 16'hFFFF},
      {OP_TICK,   3'b010, 16'h5555},
      {OP_SAMPLE, 3'b001, 16'hAAAA},  // level was cleared: rise again
      {OP_TICK,   3'b001, 16'hAAAA},
      {OP_TICK,   3'b111, 16'h0F0F},
      {OP_TICK,   3'b000, 16'hF0F0},
      {OP_SAMPLE, 3'b001, 16'h0010}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i]);
    drain_results();

    stim_sensor = sb.listen_idx;
    run_phase(360, 1'b0, 1'b0);
    drain_results();
    run_phase(360, 1'b1, 1'b0);
    drain_results();
    run_phase(360, 1'b0, 1'b1);
    drain_results();
    run_phase(350, 1'b1, 1'b1);
    drain_results();
    repeat (4) @(posedge clk);

    failures = sb.field_errors + sb.stray_results + sb.expected_q.size();
    if (sb.expected_q.size() != 0) begin
      $display("ERROR: %0d results never arrived", sb.expected_q.size());
    end
    $display("Sent %0d requests (%0d ticks), directed edge cases plus four idle mixes;",
             requests_sent, ticks_sent);
    $display("checked %0d results, %0d field errors, %0d stray results.",
             sb.checked, sb.field_errors, sb.stray_results);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
